@@ src/orlq_pkg.sv @@
// Package for the ring log with key queries: beat structs, command and
// status codes. No dependencies.
package orlq_pkg;

    localparam int unsigned MaxOut = 32;

    typedef enum logic [1:0] {
        CMD_APPEND   = 2'd0,
        CMD_RECENT   = 2'd1,
        CMD_DISTINCT = 2'd2,
        CMD_DUMP     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SKIPPED  = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_RSVD     = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] learner_key;
        logic        key_registered;
        logic [7:0]  topic_code;
        logic [3:0]  difficulty_level;
        logic [7:0]  score_value;
        logic        passed_flag;
        logic [5:0]  recent_limit;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] sequence_number;
        logic [31:0] key_out;
        logic [7:0]  topic_out;
        logic [3:0]  difficulty_out;
        logic [7:0]  score_out;
        logic        passed_out;
        logic        last_result;
    } out_beat_t;

    typedef struct packed {
        logic [7:0] topic;
        logic [3:0] difficulty;
        logic [7:0] score;
        logic       passed;
    } payload_t;

endpackage

@@ src/overwrite_ring_log_with_key_query_top.sv @@
// Top level of the ring log with key queries.
// Depends on orlq_pkg.
//
// Ring log of LOG_DEPTH records with overwrite of the oldest. The block takes
// one input beat at a time and is not ready until that beat's last result
// has left the output register. A stalled output holds the sequencer. An
// append is accepted, writes the record and loads the result, then hands
// the result over. A query walks the stored entries through one registered
// read port and one comparator.
// - Recent records: entries are checked one at a time, newest first. The
//   walk stops once enough matches are found. Then each result is read
//   and sent through the emit, load and out states.
// - Dump: results are sent the same way, oldest first, up to the cap.
// - Distinct keys: each entry is compared with the keys already found until
//   one matches, else its key is recorded. Then the recorded keys are sent.
// - Empty answer: one not-found status beat after the walk.
module overwrite_ring_log_with_key_query_top #(
    parameter int unsigned LOG_DEPTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  orlq_pkg::in_beat_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output orlq_pkg::out_beat_t out_data,
    input  logic              cfg_we,
    input  logic [5:0]        cfg_wdata
);
    import orlq_pkg::*;

    localparam int unsigned AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int unsigned CW = $clog2(LOG_DEPTH + 1);
    localparam int unsigned PW = $clog2(MaxOut);
    localparam int unsigned FW = $clog2(MaxOut + 1);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_APPND = 14'b00000000000010,
        S_SCAN  = 14'b00000000000100,
        S_CHECK = 14'b00000000001000,
        S_EMIT  = 14'b00000000010000,
        S_LOAD  = 14'b00000000100000,
        S_OUT   = 14'b00000001000000,
        S_FETCH = 14'b00000010000000,
        S_SEEN  = 14'b00000100000000,
        S_CMP   = 14'b00001000000000,
        S_DRD   = 14'b00010000000000,
        S_DOUT  = 14'b00100000000000,
        S_SEND  = 14'b01000000000000,
        S_WAIT  = 14'b10000000000000
    } state_t;

    // Log memories
    logic [31:0] num_mem [LOG_DEPTH];
    logic [31:0] key_mem [LOG_DEPTH];
    payload_t    pay_mem [LOG_DEPTH];
    // Picked slots and seen keys
    logic [AW-1:0] pick_mem [MaxOut];
    logic [31:0]   seen_mem [MaxOut];

    state_t state_reg, state_next;
    logic [AW-1:0] oldest_reg;
    logic [CW-1:0] count_reg;
    logic [31:0]   nnum_reg;
    logic [5:0]    cap_reg;
    in_beat_t      cmd_reg;
    logic [CW-1:0] idx_reg, idx_next;
    logic [FW-1:0] got_reg, want_reg, j_reg;
    logic [FW-1:0] got_next, want_next, j_next;
    logic [31:0]   rd_num, rd_key, rd_seen;
    payload_t      rd_pay;
    logic [AW-1:0] rd_pick;
    out_beat_t     obuf_reg, obuf_next;
    logic          ovalid_reg, ovalid_next;

    // Effective cap
    logic [5:0] cap_eff;
    always_comb
    begin
        if (cap_reg == '0)
            cap_eff = 6'd1;
        else if (cap_reg > 6'(MaxOut))
            cap_eff = 6'(MaxOut);
        else
            cap_eff = cap_reg;
    end

    // Ring slot of logical index
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [CW-1:0] i);
        logic [AW:0] s;
        s = {1'b0, base} + (AW+1)'(i);
        if (s >= (AW+1)'(LOG_DEPTH))
            s = s - (AW+1)'(LOG_DEPTH);
        return s[AW-1:0];
    endfunction

    logic          out_free;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_slot;
    logic          wr_en;
    logic          emit_last;

    assign out_free  = !ovalid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;
    assign out_data  = obuf_reg;

    // Read address: the walk reads idx-1, recent emit reads the picked slot
    always_comb
    begin
        if (state_reg == S_SCAN)
            rd_addr = slot_of(oldest_reg, idx_reg - CW'(1));
        else if (cmd_reg.command == CMD_RECENT
                 && (state_reg == S_LOAD || state_reg == S_OUT))
            rd_addr = rd_pick;
        else
            rd_addr = slot_of(oldest_reg, idx_reg);
    end

    assign wr_slot = (count_reg < CW'(LOG_DEPTH)) ? slot_of(oldest_reg, count_reg)
                                                  : oldest_reg;
    assign wr_en = (state_reg == S_APPND) && cmd_reg.key_registered && out_free;

    // Log memory write and registered reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            num_mem[wr_slot] <= nnum_reg;
            key_mem[wr_slot] <= cmd_reg.learner_key;
            pay_mem[wr_slot] <= payload_t'{cmd_reg.topic_code, cmd_reg.difficulty_level,
                                          cmd_reg.score_value, cmd_reg.passed_flag};
        end
        rd_num <= num_mem[rd_addr];
        rd_key <= key_mem[rd_addr];
        rd_pay <= pay_mem[rd_addr];
    end

    // Pick list and seen list
    logic          pick_we, seen_we;
    logic [PW-1:0] pick_ra;
    assign pick_ra = PW'(got_reg - FW'(1));
    always_ff @(posedge clk)
    begin
        if (pick_we)
            pick_mem[got_reg[PW-1:0]] <= slot_of(oldest_reg, idx_reg - CW'(1));
        if (seen_we)
            seen_mem[got_reg[PW-1:0]] <= rd_key;
        rd_pick <= pick_mem[pick_ra];
        rd_seen <= seen_mem[j_reg[PW-1:0]];
    end

    // Final beat of a recent or dump answer
    assign emit_last = (cmd_reg.command == CMD_RECENT)
                     ? (got_reg == FW'(1))
                     : (32'(idx_reg) + 32'd1 == 32'(want_reg));

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        got_next    = got_reg;
        want_next   = want_reg;
        j_next      = j_reg;
        obuf_next   = obuf_reg;
        ovalid_next = ovalid_reg && !out_ready;
        pick_we     = 1'b0;
        seen_we     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                got_next = '0;
                j_next   = '0;
                idx_next = '0;
                if (in_valid)
                begin
                    unique case (in_data.command)
                        CMD_APPEND: state_next = S_APPND;
                        CMD_RECENT:
                        begin
                            want_next = (in_data.recent_limit < cap_eff)
                                      ? FW'(in_data.recent_limit) : FW'(cap_eff);
                            idx_next   = count_reg;
                            state_next = S_SCAN;
                        end
                        CMD_DISTINCT: state_next = S_FETCH;
                        CMD_DUMP:
                        begin
                            want_next = (32'(cap_eff) < 32'(count_reg)) ? FW'(cap_eff)
                                                                        : FW'(count_reg);
                            state_next = (count_reg == '0) ? S_SEND : S_EMIT;
                        end
                    endcase
                end
            end
            S_APPND:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    obuf_next = '0;
                    obuf_next.last_result = 1'b1;
                    if (cmd_reg.key_registered)
                    begin
                        obuf_next.status = ST_OK;
                        obuf_next.sequence_number = nnum_reg;
                        obuf_next.key_out = cmd_reg.learner_key;
                        obuf_next.topic_out = cmd_reg.topic_code;
                        obuf_next.difficulty_out = cmd_reg.difficulty_level;
                        obuf_next.score_out = cmd_reg.score_value;
                        obuf_next.passed_out = cmd_reg.passed_flag;
                    end
                    else
                        obuf_next.status = ST_SKIPPED;
                    state_next = S_WAIT;
                end
            end
            // Walk newest to oldest; read of idx-1 issued here
            S_SCAN:
            begin
                if (idx_reg == '0 || got_reg >= want_reg)
                    state_next = (got_reg == '0) ? S_SEND : S_EMIT;
                else
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (rd_key == cmd_reg.learner_key)
                begin
                    pick_we  = 1'b1;
                    got_next = got_reg + FW'(1);
                end
                idx_next   = idx_reg - CW'(1);
                state_next = S_SCAN;
            end
            // Recent pops the pick list newest pick last; dump walks forward
            S_EMIT: state_next = S_LOAD;
            S_LOAD: state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    obuf_next = '0;
                    obuf_next.status = ST_OK;
                    obuf_next.sequence_number = rd_num;
                    obuf_next.key_out = rd_key;
                    obuf_next.topic_out = rd_pay.topic;
                    obuf_next.difficulty_out = rd_pay.difficulty;
                    obuf_next.score_out = rd_pay.score;
                    obuf_next.passed_out = rd_pay.passed;
                    obuf_next.last_result = emit_last;
                    if (cmd_reg.command == CMD_RECENT)
                        got_next = got_reg - FW'(1);
                    else
                        idx_next = idx_reg + CW'(1);
                    state_next = emit_last ? S_WAIT : S_EMIT;
                end
            end
            // Distinct: read entry key at idx
            S_FETCH:
            begin
                j_next = '0;
                if (idx_reg >= count_reg || got_reg >= FW'(cap_eff))
                    state_next = (got_reg == '0) ? S_SEND : S_DRD;
                else
                    state_next = S_SEEN;
            end
            // Read one seen key, or record a new key once the list is done
            S_SEEN:
            begin
                if (j_reg >= got_reg)
                begin
                    seen_we    = 1'b1;
                    got_next   = got_reg + FW'(1);
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_FETCH;
                end
                else
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                if (rd_seen == rd_key)
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_FETCH;
                end
                else
                begin
                    j_next     = j_reg + FW'(1);
                    state_next = S_SEEN;
                end
            end
            // Distinct emit: read seen key j, then send it
            S_DRD: state_next = S_DOUT;
            S_DOUT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    obuf_next = '0;
                    obuf_next.key_out = rd_seen;
                    obuf_next.last_result = (j_reg + FW'(1) == got_reg);
                    j_next = j_reg + FW'(1);
                    state_next = (j_reg + FW'(1) == got_reg) ? S_WAIT : S_DRD;
                end
            end
            // Empty answer
            S_SEND:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    obuf_next = '0;
                    obuf_next.status = ST_NOTFOUND;
                    obuf_next.last_result = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            oldest_reg <= '0;
            count_reg  <= '0;
            nnum_reg   <= 32'd1;
            cap_reg    <= 6'd32;
            ovalid_reg <= 1'b0;
            obuf_reg   <= '0;
            idx_reg    <= '0;
            got_reg    <= '0;
            want_reg   <= '0;
            j_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            obuf_reg   <= obuf_next;
            idx_reg    <= idx_next;
            got_reg    <= got_next;
            want_reg   <= want_next;
            j_reg      <= j_next;
            if (cfg_we)
                cap_reg <= cfg_wdata;
            if (wr_en)
            begin
                nnum_reg <= nnum_reg + 32'd1;
                if (count_reg < CW'(LOG_DEPTH))
                    count_reg <= count_reg + CW'(1);
                else
                    oldest_reg <= (oldest_reg == AW'(LOG_DEPTH - 1)) ? '0
                                                                     : oldest_reg + AW'(1);
            end
        end
    end

    // Input beat register
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            cmd_reg <= in_data;
    end

endmodule

@@ src/orlq_checker.sv @@
// Port-level checker for the ring log, bound to the top level.
// Depends on orlq_pkg.
module orlq_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input orlq_pkg::out_beat_t out_data
);
    import orlq_pkg::*;

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    // No input is taken back to back: ready drops after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken twice back to back");

    // Status codes other than record carry the last mark
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.last_result)
        else $error("error status without last mark");

    // Reserved status never shows
    a_rsvd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status != ST_RSVD)
        else $error("reserved status");

endmodule

bind overwrite_ring_log_with_key_query_top orlq_checker u_orlq_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
